// ===== rtl/utf8ld_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8ld_pkg
// Shared widths, constants and types for the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8ld_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CpW    = 31;
	localparam int unsigned LeftW  = 3;
	localparam int unsigned TdataW = 32;

	localparam logic [CpW-1:0] ReplacementCp = CpW'(32'h0000_FFFD);

	// Number of trailing bytes that each lead byte form announces.
	localparam logic [LeftW-1:0] LeftNone  = 3'd0;
	localparam logic [LeftW-1:0] LeftTwo   = 3'd1;
	localparam logic [LeftW-1:0] LeftThree = 3'd2;
	localparam logic [LeftW-1:0] LeftFour  = 3'd3;
	localparam logic [LeftW-1:0] LeftFive  = 3'd4;
	localparam logic [LeftW-1:0] LeftSix   = 3'd5;
	localparam logic [LeftW-1:0] LeftMax   = LeftSix;

	// Outcome of one decode step: next state and the optional result.
	typedef struct packed {
		logic [LeftW-1:0] next_left;
		logic [CpW-1:0]   next_partial;
		logic             emit;
		logic [CpW-1:0]   code_point;
		logic             bad_lead;
	} step_res_t;

endpackage

// ===== rtl/utf8ld_step.sv =====
// ----------------------------------------------------------------------------
// utf8ld_step
// Combinational decode of one byte against the pending sequence state.
// ----------------------------------------------------------------------------
module utf8ld_step
	import utf8ld_pkg::*;
(
	input  logic [ByteW-1:0] in_byte,
	input  logic [LeftW-1:0] bytes_left,
	input  logic [CpW-1:0]   partial_value,
	output step_res_t        res
);

	logic [CpW-1:0] shifted;

	assign shifted = {partial_value[CpW-7:0], in_byte[5:0]};

	always_comb begin
		res = '0;
		if (bytes_left != LeftNone) begin
			// Any byte counts as a trailing byte inside a sequence.
			res.next_left = bytes_left - 3'd1;
			if (bytes_left == LeftTwo) begin
				res.emit         = 1'b1;
				res.code_point   = shifted;
				res.next_partial = '0;
			end else begin
				res.next_partial = shifted;
			end
		end else if (in_byte[7] == 1'b0) begin
			res.emit       = 1'b1;
			res.code_point = CpW'(in_byte[6:0]);
		end else if (in_byte[7:5] == 3'b110) begin
			res.next_left    = LeftTwo;
			res.next_partial = CpW'(in_byte[4:0]);
		end else if (in_byte[7:4] == 4'b1110) begin
			res.next_left    = LeftThree;
			res.next_partial = CpW'(in_byte[3:0]);
		end else if (in_byte[7:3] == 5'b11110) begin
			res.next_left    = LeftFour;
			res.next_partial = CpW'(in_byte[2:0]);
		end else if (in_byte[7:2] == 6'b111110) begin
			res.next_left    = LeftFive;
			res.next_partial = CpW'(in_byte[1:0]);
		end else if (in_byte[7:1] == 7'b1111110) begin
			res.next_left    = LeftSix;
			res.next_partial = CpW'(in_byte[0]);
		end else begin
			// Stray continuation byte, 0xFE or 0xFF.
			res.emit       = 1'b1;
			res.code_point = ReplacementCp;
			res.bad_lead   = 1'b1;
		end
	end

endmodule

// ===== rtl/utf8ld_out_reg.sv =====
// ----------------------------------------------------------------------------
// utf8ld_out_reg
// Result register that holds one decoded code point until it is taken.
// ----------------------------------------------------------------------------
module utf8ld_out_reg
	import utf8ld_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic [CpW-1:0] load_cp,
	input  logic           load_bad,
	input  logic           take,
	output logic           valid,
	output logic [CpW-1:0] code_point,
	output logic           bad_lead,
	output logic           free
);

	logic           valid_q;
	logic [CpW-1:0] cp_q;
	logic           bad_q;

	assign free = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q  <= load_cp;
			bad_q <= load_bad;
		end
	end

	assign valid      = valid_q;
	assign code_point = cp_q;
	assign bad_lead   = bad_q;

endmodule

// ===== rtl/utf8_lenient_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_unit
// Lenient UTF-8 decoder: one byte per transaction in, one code point out.
// ----------------------------------------------------------------------------
//
//   Channel  | Dir | tdata (low bit up)            | tuser
//   ---------+-----+-------------------------------+----------
//   s_axis   | in  | in_byte[7:0]                  | -
//   m_axis   | out | code_point[30:0], zero pad[31]| bad_lead
//
// Each byte is held in the input register, then the decode logic loads the
// result register. A new byte can be accepted in every cycle while the
// output is not stalled; throughput is one byte per clock, set by the
// single decode stage between the input register and the result register.
// Reset clears the sequence state and all valid flags. A stalled output only
// blocks the input register when the byte held there would produce a result.
//
module utf8_lenient_decoder_unit
	import utf8ld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ByteW-1:0]  s_tdata,   // [7:0] in_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TdataW-1:0] m_tdata,   // [30:0] code_point, [31] zero
	output logic              m_tuser    // [0] bad_lead
);

	// Input register stage.
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;

	// Pending sequence state.
	logic [LeftW-1:0] left_q;
	logic [CpW-1:0]   partial_q;

	step_res_t        res;
	logic             out_free;
	logic             s1_go;
	logic [CpW-1:0]   out_cp;

	utf8ld_step u_step (
		.in_byte       (byte_s1),
		.bytes_left    (left_q),
		.partial_value (partial_q),
		.res           (res)
	);

	// The held byte moves on when it yields no result or the result slot frees.
	assign s1_go    = valid_s1 && (!res.emit || out_free);
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			left_q    <= LeftNone;
			partial_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s1_go) begin
				left_q    <= res.next_left;
				partial_q <= res.next_partial;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	utf8ld_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_go && res.emit),
		.load_cp    (res.code_point),
		.load_bad   (res.bad_lead),
		.take       (m_tready),
		.valid      (m_tvalid),
		.code_point (out_cp),
		.bad_lead   (m_tuser),
		.free       (out_free)
	);

	assign m_tdata = {1'b0, out_cp};

	// A result produced by the decode stage is offered in the next cycle.
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && res.emit |=> m_tvalid)
		else $error("decoded result not presented");

	// Emitting a result always closes the pending sequence.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && res.emit |=> left_q == LeftNone)
		else $error("sequence still pending after emit");

	// No sequence announces more than five trailing bytes.
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= LeftMax)
		else $error("trailing byte count out of range");

	// A flagged result always carries the replacement character.
	a_bad_cp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> out_cp == ReplacementCp)
		else $error("bad lead without replacement character");

endmodule

// ===== tb/tb_utf8_lenient_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_lenient_decoder_unit
// Self-checking bench for the lenient UTF-8 decoder. Bytes go in as stream
// transactions with random gaps and the output is stalled at random. A
// scoreboard decodes every accepted byte on its own and compares each code
// point that comes out with the oldest code point it still expects.
// ----------------------------------------------------------------------------
module tb_utf8_lenient_decoder_unit;
	import utf8ld_pkg::*;

	localparam int unsigned CycleLimit  = 300000;
	localparam int unsigned RandomBytes = 725;
	localparam int unsigned DrainEvery  = 200;

	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           bad;
	} cp_res_t;

	// Decodes accepted bytes into expected code points and checks results.
	class cp_scoreboard;
		logic [LeftW-1:0] trail_cnt;
		logic [CpW-1:0]   gathered;
		cp_res_t          expected_cps[$];
		int               errors;

		function new();
			trail_cnt = LeftNone;
			gathered  = '0;
			errors    = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void push_cp(logic [CpW-1:0] cp, logic bad);
			cp_res_t r;
			r.cp  = cp;
			r.bad = bad;
			expected_cps.push_back(r);
		endfunction

		// Any byte inside a sequence counts as a trailing byte; only its low
		// six bits are kept, whatever its top bits say.
		function void note_byte(logic [ByteW-1:0] b);
			if (trail_cnt != LeftNone) begin
				gathered  = {gathered[CpW-7:0], b[5:0]};
				trail_cnt = trail_cnt - 3'd1;
				if (trail_cnt == LeftNone) begin
					push_cp(gathered, 1'b0);
					gathered = '0;
				end
			end else if (!b[7]) begin
				push_cp(CpW'(b), 1'b0);
			end else if (b[7:5] == 3'b110) begin
				trail_cnt = LeftTwo;
				gathered  = CpW'(b[4:0]);
			end else if (b[7:4] == 4'b1110) begin
				trail_cnt = LeftThree;
				gathered  = CpW'(b[3:0]);
			end else if (b[7:3] == 5'b11110) begin
				trail_cnt = LeftFour;
				gathered  = CpW'(b[2:0]);
			end else if (b[7:2] == 6'b111110) begin
				trail_cnt = LeftFive;
				gathered  = CpW'(b[1:0]);
			end else if (b[7:1] == 7'b1111110) begin
				trail_cnt = LeftSix;
				gathered  = CpW'(b[0]);
			end else begin
				// Stray continuation byte, 0xFE or 0xFF with nothing pending.
				gathered = '0;
				push_cp(ReplacementCp, 1'b1);
			end
		endfunction

		task check_result(logic [TdataW-1:0] data, logic flag);
			cp_res_t want;
			if (expected_cps.size() == 0) begin
				report($sformatf("unexpected result cp=%h bad=%b", data[CpW-1:0], flag));
			end else begin
				want = expected_cps.pop_front();
				if (data[CpW-1:0] !== want.cp)
					report($sformatf("code_point %h, expected %h", data[CpW-1:0], want.cp));
				if (data[TdataW-1] !== 1'b0)
					report($sformatf("pad bit of tdata is %b", data[TdataW-1]));
				if (flag !== want.bad)
					report($sformatf("bad_lead %b, expected %b", flag, want.bad));
			end
		endtask
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ByteW-1:0]  s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [TdataW-1:0] m_tdata;
	logic              m_tuser;

	cp_scoreboard sb = new();
	int unsigned  cycles     = 0;
	int unsigned  bytes_sent = 0;
	bit           tx_calm    = 1'b0;
	int           rx_stall   = 0;
	int           rx_phase   = 0;
	bit           rx_calm    = 1'b0;
	int           rx_roll;

	// Directed bytes: the single-byte extremes, stray continuation bytes, 0xFE
	// and 0xFF, a two-byte form whose trailing byte is not a continuation
	// byte, then three-, four-, five- and six-byte forms, the last giving the
	// widest code point.
	logic [ByteW-1:0] directed_bytes [26] = '{
		8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
		8'hC3, 8'h41,
		8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h9F, 8'h98, 8'h80,
		8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
		8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF
	};

	utf8_lenient_decoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_utf8_lenient_decoder_unit NOT OK");
			$finish;
		end
	end

	// Both sides are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (arst_n && s_tvalid && s_tready)
			sb.note_byte(s_tdata);
	end

	// Output back-pressure: short stalls mostly, a few long ones, and calm
	// stretches with the output always ready.
	always @(negedge clk) begin
		if (rx_phase == 0) begin
			rx_calm  = ($urandom_range(0, 3) == 0);
			rx_phase = $urandom_range(50, 300);
		end
		rx_phase--;
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			rx_roll = $urandom_range(0, 99);
			if (!rx_calm && rx_roll < 20)
				rx_stall = (rx_roll < 2) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Starts and ends at a falling edge. A byte that directly follows keeps
	// tvalid high without lowering it in between.
	task send_byte(logic [ByteW-1:0] b);
		int unsigned gap;
		gap = pick_gap();
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task wait_results_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_cps.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A well-formed sequence of random length and content; now and then a
	// trailing byte carries arbitrary top bits.
	task send_sequence();
		int unsigned      trail;
		logic [ByteW-1:0] lead;
		trail = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
		lead  = $urandom_range(0, 255);
		case (trail)
			0: lead[7]   = 1'b0;
			1: lead[7:5] = 3'b110;
			2: lead[7:4] = 4'b1110;
			3: lead[7:3] = 5'b11110;
			4: lead[7:2] = 6'b111110;
			default: lead[7:1] = 7'b1111110;
		endcase
		send_byte(lead);
		repeat (trail) begin
			if ($urandom_range(0, 99) < 85)
				send_byte({2'b10, 6'($urandom_range(0, 63))});
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int unsigned      roll;
		int unsigned      next_drain;
		logic [ByteW-1:0] stray;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		wait_results_drained();

		next_drain = bytes_sent + DrainEvery;
		while (bytes_sent < RandomBytes) begin
			if ($urandom_range(0, 49) == 0)
				tx_calm = ~tx_calm;
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				send_sequence();
			end else if (roll < 90) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// Invalid lead: a stray continuation byte, 0xFE or 0xFF.
				stray = {2'b10, 6'($urandom_range(0, 63))};
				if ($urandom_range(0, 3) == 0)
					stray = {7'b1111111, 1'($urandom_range(0, 1))};
				send_byte(stray);
			end
			if (bytes_sent >= next_drain) begin
				wait_results_drained();
				next_drain = bytes_sent + DrainEvery;
			end
		end

		// The stream ends in the middle of a sequence: nothing more may come.
		send_byte(8'hE2);
		s_tvalid <= 1'b0;

		while (sb.expected_cps.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("tb_utf8_lenient_decoder_unit OK");
		else
			$display("tb_utf8_lenient_decoder_unit NOT OK");
		$finish;
	end

endmodule

// ===== utf8_lenient_decoder_unit.f =====
rtl/utf8ld_pkg.sv
rtl/utf8ld_step.sv
rtl/utf8ld_out_reg.sv
rtl/utf8_lenient_decoder_unit.sv
tb/tb_utf8_lenient_decoder_unit.sv
